/* rtl/gkc_pkg.sv */
// Shared types and constants for the Geffe keystream cipher.
package gkc_pkg;

  localparam int unsigned WidthA = 23;
  localparam int unsigned WidthB = 31;
  localparam int unsigned WidthC = 39;
  localparam int unsigned TapA   = 18;
  localparam int unsigned TapB   = 28;
  localparam int unsigned TapC   = 35;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = WidthC;

  localparam logic [CfgIdxW-1:0] CfgSeedA = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSeedB = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSeedC = 2'd2;

  typedef struct packed {
    logic data_bit;
    logic restart;
  } in_word_t;

  typedef struct packed {
    logic cipher_bit;
    logic key_bit;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic adv;
  } cell_ctrl_t;

endpackage

/* rtl/gkc_cell.sv */
// One bit cell of a shift register chain: seed load, shift from neighbor.
module gkc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gkc_pkg::cell_ctrl_t ctrl_i,
  input  logic              init_i,
  input  logic              seed_i,
  input  logic              shift_i,
  output logic              cur_o
);
  import gkc_pkg::*;

  logic bit_q;
  logic bit_d;

  assign cur_o = ctrl_i.load ? seed_i : bit_q;
  assign bit_d = ctrl_i.adv ? shift_i : bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= init_i;
    end else begin
      bit_q <= bit_d;
    end
  end

endmodule

/* rtl/gkc_out_stage.sv */
// Geffe combiner and output register with stall handling.
module gkc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               data_bit_i,
  input  logic               x1_i,
  input  logic               x2_i,
  input  logic               x3_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output gkc_pkg::out_word_t out_word_o
);
  import gkc_pkg::*;

  logic      valid_q;
  logic      valid_d;
  out_word_t word_q;
  out_word_t word_d;
  logic      key;

  assign key = x1_i ? x2_i : x3_i;

  always_comb begin
    valid_d = valid_q & out_stall_i;
    word_d  = word_q;
    if (accept_i) begin
      valid_d           = 1'b1;
      word_d.key_bit    = key;
      word_d.cipher_bit = data_bit_i ^ key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

/* rtl/geffe_keystream_cipher_top.sv */
// Top level of the Geffe keystream cipher: seed registers, three cell chains, output stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per cycle while
//   in_stall_o is low: a data bit and a restart flag. Restart reloads all
//   three shift registers from the seed registers before that bit is combined.
//   Output channel (out_valid_o / out_stall_i) returns one word per input
//   word: the keystream bit and the data bit XORed with it.
//   out_valid_o rises in the cycle after acceptance; throughput is one word per
//   cycle unless the output stalls, set by the single-step advance of the cell chains.
//   The config channel (cfg_valid_i / cfg_ready_o) is always ready; index 0,
//   1 and 2 write seed A, B and C, other indexes are dropped. A new seed takes
//   effect at the next restart.
//   Reset sets every seed to 1 and also resets each shift register to the value 1.
//   When the receiver stalls with a word held, in_stall_o rises in the same
//   cycle and the chains hold; the held word stays unchanged.
module geffe_keystream_cipher_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gkc_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gkc_pkg::out_word_t             out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gkc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [gkc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import gkc_pkg::*;

  logic [WidthA-1:0] seed_a_q;
  logic [WidthB-1:0] seed_b_q;
  logic [WidthC-1:0] seed_c_q;
  logic [WidthA-1:0] cur_a;
  logic [WidthB-1:0] cur_b;
  logic [WidthC-1:0] cur_c;
  logic [WidthA-1:0] shift_a;
  logic [WidthB-1:0] shift_b;
  logic [WidthC-1:0] shift_c;
  logic              accept;
  logic              cfg_we;
  cell_ctrl_t        ctrl;

  assign in_stall_o  = out_valid_o & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  assign ctrl.load = accept & in_word_i.restart;
  assign ctrl.adv  = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a_q <= WidthA'(1);
      seed_b_q <= WidthB'(1);
      seed_c_q <= WidthC'(1);
    end else if (cfg_we) begin
      case (cfg_idx_i)
        CfgSeedA: seed_a_q <= cfg_data_i[WidthA-1:0];
        CfgSeedB: seed_b_q <= cfg_data_i[WidthB-1:0];
        CfgSeedC: seed_c_q <= cfg_data_i[WidthC-1:0];
        default: ;
      endcase
    end
  end

  assign shift_a = {cur_a[0] ^ cur_a[TapA], cur_a[WidthA-1:1]};
  assign shift_b = {cur_b[0] ^ cur_b[TapB], cur_b[WidthB-1:1]};
  assign shift_c = {cur_c[0] ^ cur_c[TapC], cur_c[WidthC-1:1]};

  for (genvar i = 0; i < WidthA; i++) begin : g_cell_a
    gkc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .init_i  (i == 0),
      .seed_i  (seed_a_q[i]),
      .shift_i (shift_a[i]),
      .cur_o   (cur_a[i])
    );
  end

  for (genvar i = 0; i < WidthB; i++) begin : g_cell_b
    gkc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .init_i  (i == 0),
      .seed_i  (seed_b_q[i]),
      .shift_i (shift_b[i]),
      .cur_o   (cur_b[i])
    );
  end

  for (genvar i = 0; i < WidthC; i++) begin : g_cell_c
    gkc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .init_i  (i == 0),
      .seed_i  (seed_c_q[i]),
      .shift_i (shift_c[i]),
      .cur_o   (cur_c[i])
    );
  end

  gkc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_bit_i  (in_word_i.data_bit),
    .x1_i        (cur_a[WidthA-1]),
    .x2_i        (cur_b[WidthB-1]),
    .x3_i        (cur_c[WidthC-1]),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

/* rtl/gkc_checker.sv */
// Port-level checks for the Geffe keystream cipher and their bind.
module gkc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input gkc_pkg::in_word_t            in_word_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input gkc_pkg::out_word_t           out_word_o
);
  import gkc_pkg::*;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("held output word changed");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word produced no output");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !in_acc |=> !out_valid_o)
    else $error("output word repeated");

  a_cipher: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_word_o.cipher_bit ^ out_word_o.key_bit) == $past(in_word_i.data_bit))
    else $error("cipher bit does not match data and key");

endmodule

bind geffe_keystream_cipher_top gkc_checker u_gkc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

/* tb/tb_geffe_keystream_cipher_top.sv */
// Self-checking testbench for the Geffe keystream cipher with a built-in keystream predictor.
module tb_geffe_keystream_cipher_top;
  import gkc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned CycleLimit = 500000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_word_t            in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_word_t           out_word_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic [WidthA-1:0] seed_a_q, lfsr_a;
  logic [WidthB-1:0] seed_b_q, lfsr_b;
  logic [WidthC-1:0] seed_c_q, lfsr_c;

  out_word_t   pending_words[$];
  int unsigned words_in;
  int unsigned cfg_writes;
  int unsigned mismatches;
  int unsigned cycles;
  bit          tx_jitter;
  bit          rx_jitter;
  bit          hold_req;
  int unsigned hold_len;

  geffe_keystream_cipher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_word_t geffe_next_word(in_word_t w);
    out_word_t r;
    logic      key;
    if (w.restart) begin
      lfsr_a = seed_a_q;
      lfsr_b = seed_b_q;
      lfsr_c = seed_c_q;
    end
    key = lfsr_a[WidthA-1] ? lfsr_b[WidthB-1] : lfsr_c[WidthC-1];
    lfsr_a = {lfsr_a[0] ^ lfsr_a[TapA], lfsr_a[WidthA-1:1]};
    lfsr_b = {lfsr_b[0] ^ lfsr_b[TapB], lfsr_b[WidthB-1:1]};
    lfsr_c = {lfsr_c[0] ^ lfsr_c[TapC], lfsr_c[WidthC-1:1]};
    r.cipher_bit = w.data_bit ^ key;
    r.key_bit    = key;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          report_mismatch("output word with nothing expected");
        end else begin
          want = pending_words.pop_front();
          if (out_word_o.cipher_bit !== want.cipher_bit)
            report_mismatch($sformatf("cipher_bit got %b want %b",
                                      out_word_o.cipher_bit, want.cipher_bit));
          if (out_word_o.key_bit !== want.key_bit)
            report_mismatch($sformatf("key_bit got %b want %b",
                                      out_word_o.key_bit, want.key_bit));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pending_words.push_back(geffe_next_word(in_word_i));
        words_in++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_i)
          CfgSeedA: seed_a_q = cfg_data_i[WidthA-1:0];
          CfgSeedB: seed_b_q = cfg_data_i[WidthB-1:0];
          CfgSeedC: seed_c_q = cfg_data_i[WidthC-1:0];
          default: ;
        endcase
        cfg_writes++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (rx_jitter && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic data_bit, logic restart);
    int unsigned n0;
    n0 = words_in;
    in_valid_i         <= 1'b1;
    in_word_i.data_bit <= data_bit;
    in_word_i.restart  <= restart;
    do @(negedge clk_i); while (words_in == n0);
    if (tx_jitter && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_seed(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    int unsigned n0;
    n0 = cfg_writes;
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (cfg_writes == n0);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] pick_seed();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CfgDataW'(1);
      default: return r[CfgDataW-1:0];
    endcase
  endfunction

  task automatic test_reset_seeds();
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
  endtask

  task automatic test_restart_flag();
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
  endtask

  task automatic test_seed_extremes();
    drain();
    write_seed(CfgSeedA, '1);
    write_seed(CfgSeedB, '1);
    write_seed(CfgSeedC, '1);
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
  endtask

  task automatic test_zero_seeds();
    drain();
    write_seed(CfgSeedA, '0);
    write_seed(CfgSeedB, '0);
    write_seed(CfgSeedC, '0);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
  endtask

  task automatic test_midstream_seed();
    drain();
    write_seed(CfgSeedA, pick_seed());
    write_seed(CfgSeedB, pick_seed());
    write_seed(CfgSeedC, pick_seed());
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b0);
  endtask

  task automatic test_unused_index();
    drain();
    write_seed(CfgUnused, '1);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
  endtask

  task automatic test_backpressure();
    drain();
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    hold_len  = 300;
    hold_req  = 1'b1;
    for (int i = 0; i < 80; i++) begin
      send_word(1'($urandom_range(0, 1)), i == 40);
    end
    drain();
  endtask

  task automatic test_random_streams(int unsigned phases, int unsigned words, bit quiet);
    for (int unsigned p = 0; p < phases; p++) begin
      drain();
      if ($urandom_range(0, 1)) write_seed(CfgSeedA, pick_seed());
      if ($urandom_range(0, 1)) write_seed(CfgSeedB, pick_seed());
      write_seed(CfgSeedC, pick_seed());
      if ($urandom_range(0, 3) == 0) write_seed(CfgUnused, pick_seed());
      tx_jitter = quiet ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      rx_jitter = quiet ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      for (int unsigned i = 0; i < words; i++) begin
        send_word(1'($urandom_range(0, 1)), $urandom_range(0, 31) == 0);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_idx_i   = CfgSeedA;
    cfg_data_i  = '0;
    tx_jitter   = 1'b1;
    rx_jitter   = 1'b1;
    hold_req    = 1'b0;
    hold_len    = 0;
    words_in    = 0;
    cfg_writes  = 0;
    mismatches  = 0;
    cycles      = 0;
    seed_a_q    = WidthA'(1);
    seed_b_q    = WidthB'(1);
    seed_c_q    = WidthC'(1);
    lfsr_a      = WidthA'(1);
    lfsr_b      = WidthB'(1);
    lfsr_c      = WidthC'(1);
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_seeds();
    test_restart_flag();
    test_seed_extremes();
    test_zero_seeds();
    test_midstream_seed();
    test_unused_index();
    test_backpressure();
    test_random_streams(6, 150, 1'b0);
    test_random_streams(1, 100, 1'b1);

    drain();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
